### rtl/core/distance_beep_cadence_unit_assert.svh
// Assertion macros used by the cadence core RTL.
`ifndef DISTANCE_BEEP_CADENCE_UNIT_ASSERT_SVH
`define DISTANCE_BEEP_CADENCE_UNIT_ASSERT_SVH

// Same-cycle implication on clk, disabled in reset.
`define DBC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cadence unit check failed");

// Next-cycle implication on clk, disabled in reset.
`define DBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cadence unit check failed");

`endif

### rtl/core/dbc_pkg.sv
// Package: configuration and band types and constants for the cadence unit.
package dbc_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_MAX_DIST   = 3'd0,
		REG_FAST_DIST  = 3'd1,
		REG_CONT_DIST  = 3'd2,
		REG_SLOW_HIGH  = 3'd3,
		REG_SLOW_LOW   = 3'd4,
		REG_FAST_HIGH  = 3'd5,
		REG_FAST_LOW   = 3'd6,
		REG_IDLE_LOW   = 3'd7
	} reg_idx_t;

	localparam logic [7:0]  MAX_DIST_RST  = 8'd150;
	localparam logic [7:0]  FAST_DIST_RST = 8'd60;
	localparam logic [7:0]  CONT_DIST_RST = 8'd35;
	localparam logic [15:0] SLOW_HIGH_RST = 16'd250;
	localparam logic [15:0] SLOW_LOW_RST  = 16'd250;
	localparam logic [15:0] FAST_HIGH_RST = 16'd125;
	localparam logic [15:0] FAST_LOW_RST  = 16'd125;
	localparam logic [15:0] IDLE_LOW_RST  = 16'd100;

	localparam logic [15:0] LONG_HIGH_TIME_DEF = 16'd250;
	localparam logic [15:0] LONG_LOW_TIME_DEF  = 16'd250;
	localparam logic [15:0] IDLE_HIGH_TIME_DEF = 16'd100;

	typedef struct packed {
		logic [7:0]  max_distance;
		logic [7:0]  fast_distance;
		logic [7:0]  continuous_distance;
		logic [15:0] slow_high_ticks;
		logic [15:0] slow_low_ticks;
		logic [15:0] fast_high_ticks;
		logic [15:0] fast_low_ticks;
		logic [15:0] idle_low_ticks;
	} cfg_t;

	typedef struct packed {
		logic [15:0] hi;
		logic [15:0] lo;
		logic        no_obj;
		logic        cont;
	} band_t;

endpackage

### rtl/core/distance_beep_cadence_unit.sv
// Top level of the distance beep cadence unit.
// One request is one tick carrying an 8-bit obstacle distance; each request yields one
// result with tone_on, phase_high and continuous after the tick's update. A request is
// registered in the input stage, then band compare, counter decrement and phase-stretch
// check write the cadence state, which is also the result register. The
// unit takes one request per cycle at full rate; a result waits in the output register
// while the next request waits in the input stage, so throughput drops only while the
// output side stalls. A request passes the input stage, then the result register.
// Configuration goes through an APB-style port with registers at byte address 4*index.
module distance_beep_cadence_unit #(
	parameter logic [15:0] LONG_HIGH_TIME = dbc_pkg::LONG_HIGH_TIME_DEF,
	parameter logic [15:0] LONG_LOW_TIME  = dbc_pkg::LONG_LOW_TIME_DEF,
	parameter logic [15:0] IDLE_HIGH_TIME = dbc_pkg::IDLE_HIGH_TIME_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] distance
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // [0] tone_on, [1] phase_high,
	                                              // [2] continuous, [7:3] zero
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dbc_pkg::ADDR_W-1:0]  paddr,
	input  logic [dbc_pkg::DATA_W-1:0]  pwdata,
	output logic [dbc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	dbc_pkg::cfg_t  cfg;
	dbc_pkg::band_t band;
	logic [7:0]     distance_s1;
	logic           tone_on, phase_high, continuous;

	assign m_tdata = {5'd0, continuous, phase_high, tone_on};

	dbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbc_band #(
		.LONG_HIGH_TIME (LONG_HIGH_TIME),
		.LONG_LOW_TIME  (LONG_LOW_TIME),
		.IDLE_HIGH_TIME (IDLE_HIGH_TIME)
	) u_band (
		.distance (distance_s1),
		.cfg      (cfg),
		.band     (band)
	);

	dbc_cadence u_cadence (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_distance  (s_tdata),
		.distance_s1 (distance_s1),
		.band        (band),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.tone_on     (tone_on),
		.phase_high  (phase_high),
		.continuous  (continuous)
	);

endmodule

### rtl/core/dbc_regs.sv
// Configuration register file with APB-style access.
module dbc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dbc_pkg::ADDR_W-1:0]  paddr,
	input  logic [dbc_pkg::DATA_W-1:0]  pwdata,
	output logic [dbc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output dbc_pkg::cfg_t               cfg
);

	dbc_pkg::cfg_t    cfg_q;
	dbc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = dbc_pkg::reg_idx_t'(paddr[dbc_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_distance        <= dbc_pkg::MAX_DIST_RST;
			cfg_q.fast_distance       <= dbc_pkg::FAST_DIST_RST;
			cfg_q.continuous_distance <= dbc_pkg::CONT_DIST_RST;
			cfg_q.slow_high_ticks     <= dbc_pkg::SLOW_HIGH_RST;
			cfg_q.slow_low_ticks      <= dbc_pkg::SLOW_LOW_RST;
			cfg_q.fast_high_ticks     <= dbc_pkg::FAST_HIGH_RST;
			cfg_q.fast_low_ticks      <= dbc_pkg::FAST_LOW_RST;
			cfg_q.idle_low_ticks      <= dbc_pkg::IDLE_LOW_RST;
		end else if (wr_en) begin
			case (idx)
				dbc_pkg::REG_MAX_DIST:  cfg_q.max_distance        <= pwdata[7:0];
				dbc_pkg::REG_FAST_DIST: cfg_q.fast_distance       <= pwdata[7:0];
				dbc_pkg::REG_CONT_DIST: cfg_q.continuous_distance <= pwdata[7:0];
				dbc_pkg::REG_SLOW_HIGH: cfg_q.slow_high_ticks     <= pwdata[15:0];
				dbc_pkg::REG_SLOW_LOW:  cfg_q.slow_low_ticks      <= pwdata[15:0];
				dbc_pkg::REG_FAST_HIGH: cfg_q.fast_high_ticks     <= pwdata[15:0];
				dbc_pkg::REG_FAST_LOW:  cfg_q.fast_low_ticks      <= pwdata[15:0];
				dbc_pkg::REG_IDLE_LOW:  cfg_q.idle_low_ticks      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dbc_pkg::REG_MAX_DIST:  prdata = {24'd0, cfg_q.max_distance};
			dbc_pkg::REG_FAST_DIST: prdata = {24'd0, cfg_q.fast_distance};
			dbc_pkg::REG_CONT_DIST: prdata = {24'd0, cfg_q.continuous_distance};
			dbc_pkg::REG_SLOW_HIGH: prdata = {16'd0, cfg_q.slow_high_ticks};
			dbc_pkg::REG_SLOW_LOW:  prdata = {16'd0, cfg_q.slow_low_ticks};
			dbc_pkg::REG_FAST_HIGH: prdata = {16'd0, cfg_q.fast_high_ticks};
			dbc_pkg::REG_FAST_LOW:  prdata = {16'd0, cfg_q.fast_low_ticks};
			dbc_pkg::REG_IDLE_LOW:  prdata = {16'd0, cfg_q.idle_low_ticks};
			default:                prdata = '0;
		endcase
	end

endmodule

### rtl/core/dbc_band.sv
// Band classifier: picks the cadence band and its phase lengths from a distance.
module dbc_band #(
	parameter logic [15:0] LONG_HIGH_TIME = dbc_pkg::LONG_HIGH_TIME_DEF,
	parameter logic [15:0] LONG_LOW_TIME  = dbc_pkg::LONG_LOW_TIME_DEF,
	parameter logic [15:0] IDLE_HIGH_TIME = dbc_pkg::IDLE_HIGH_TIME_DEF
) (
	input  logic [7:0]     distance,
	input  dbc_pkg::cfg_t  cfg,
	output dbc_pkg::band_t band
);

	always_comb begin
		band = '0;
		if (distance > cfg.max_distance) begin
			band.hi     = IDLE_HIGH_TIME;
			band.lo     = cfg.idle_low_ticks;
			band.no_obj = 1'b1;
		end else if (distance > cfg.fast_distance) begin
			band.hi = cfg.slow_high_ticks;
			band.lo = cfg.slow_low_ticks;
		end else if (distance > cfg.continuous_distance) begin
			band.hi = cfg.fast_high_ticks;
			band.lo = cfg.fast_low_ticks;
		end else begin
			band.hi   = LONG_HIGH_TIME;
			band.lo   = LONG_LOW_TIME;
			band.cont = 1'b1;
		end
	end

endmodule

### rtl/core/dbc_cadence.sv
// Cadence core: input stage, phase counter state and result register.
module dbc_cadence (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_distance,
	output logic [7:0]     distance_s1,
	input  dbc_pkg::band_t band,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic           tone_on,
	output logic           phase_high,
	output logic           continuous
);

	logic        valid_s1;
	logic        out_valid_q;
	logic        go;
	logic        phase_q, tone_q, cont_q;
	logic [15:0] cnt_q, last_q;
	logic        phase_n, tone_n;
	logic [15:0] cnt_n, last_n;
	logic [15:0] cnt_dec, want, elapsed;
	logic        stretch;

	assign go       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go;

	assign m_tvalid   = out_valid_q;
	assign tone_on    = tone_q;
	assign phase_high = phase_q;
	assign continuous = cont_q;

	assign cnt_dec = cnt_q - 16'd1;
	assign want    = phase_q ? band.hi : band.lo;
	assign elapsed = last_q - cnt_dec;
	assign stretch = (want != last_q) && (elapsed < {1'b0, last_q[15:1]}) && (elapsed < want);

	always_comb begin
		phase_n = phase_q;
		tone_n  = tone_q;
		cnt_n   = cnt_dec;
		last_n  = last_q;
		if (cnt_q != 16'd0) begin
			if (stretch) begin
				cnt_n  = want;
				last_n = want;
			end
		end else if (!band.no_obj) begin
			if (!phase_q) begin
				phase_n = 1'b1;
				cnt_n   = band.hi;
				last_n  = band.hi;
				tone_n  = 1'b1;
			end else begin
				phase_n = 1'b0;
				cnt_n   = band.lo;
				last_n  = band.lo;
				tone_n  = band.cont ? tone_q : 1'b0;
			end
		end else begin
			phase_n = 1'b0;
			cnt_n   = band.lo;
			last_n  = band.lo;
			tone_n  = 1'b0;
		end
	end

	// hold distance of the request waiting in the input stage
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			distance_s1 <= s_distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			tone_q      <= 1'b0;
			cont_q      <= 1'b0;
			cnt_q       <= 16'd0;
			last_q      <= dbc_pkg::IDLE_LOW_RST;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (go) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_n;
				tone_q      <= tone_n;
				cont_q      <= band.cont;
				cnt_q       <= cnt_n;
				last_q      <= last_n;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`include "distance_beep_cadence_unit_assert.svh"

	`DBC_ASSERT_SAME(a_high_means_tone, phase_q, tone_q)
	`DBC_ASSERT_NEXT(a_go_gives_result, go, out_valid_q)
	`DBC_ASSERT_NEXT(a_idle_forces_low, go && band.no_obj && cnt_q == 16'd0, !phase_q && !tone_q)
	`DBC_ASSERT_NEXT(a_zero_toggles, go && !band.no_obj && cnt_q == 16'd0, phase_q != $past(phase_q))

endmodule

### sim/distance_beep_cadence_unit_tb.sv
// Testbench: distance beep cadence unit checked against a cycle-free cadence predictor.
`timescale 1ns / 1ps

module distance_beep_cadence_unit_tb;

	typedef struct packed {
		logic tone;
		logic phase;
		logic cont;
	} beep_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [7:0]                 s_tdata;  // [7:0] distance
	logic                       m_tvalid;
	logic                       m_tready;
	logic [7:0]                 m_tdata;  // [0] tone_on, [1] phase_high, [2] continuous, [7:3] zero
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [dbc_pkg::ADDR_W-1:0] paddr;
	logic [dbc_pkg::DATA_W-1:0] pwdata;
	logic [dbc_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	dbc_pkg::cfg_t cad_cfg;
	logic          cad_phase;
	logic [15:0]   cad_count;
	logic [15:0]   cad_period;
	logic          cad_tone;
	logic          cad_cont;
	beep_t         pending_beeps[$];
	beep_t         want_beep;
	int            mismatch_count;
	bit            idling_on;

	distance_beep_cadence_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** distance_beep_cadence_unit: FAILED **");
		$finish;
	end

	task automatic reset_cadence_model();
		cad_cfg = '{max_distance: dbc_pkg::MAX_DIST_RST,
			fast_distance: dbc_pkg::FAST_DIST_RST,
			continuous_distance: dbc_pkg::CONT_DIST_RST,
			slow_high_ticks: dbc_pkg::SLOW_HIGH_RST,
			slow_low_ticks: dbc_pkg::SLOW_LOW_RST,
			fast_high_ticks: dbc_pkg::FAST_HIGH_RST,
			fast_low_ticks: dbc_pkg::FAST_LOW_RST,
			idle_low_ticks: dbc_pkg::IDLE_LOW_RST};
		cad_phase  = 1'b0;
		cad_count  = 16'd0;
		cad_period = dbc_pkg::IDLE_LOW_RST;
		cad_tone   = 1'b0;
		cad_cont   = 1'b0;
	endtask

	function automatic beep_t advance_cadence(input logic [7:0] dist_in);
		dbc_pkg::band_t band;
		logic [15:0]    want;
		logic [15:0]    elapsed;
		band.no_obj = 1'b0;
		band.cont   = 1'b0;
		if (dist_in > cad_cfg.max_distance) begin
			band.hi     = dbc_pkg::IDLE_HIGH_TIME_DEF;
			band.lo     = cad_cfg.idle_low_ticks;
			band.no_obj = 1'b1;
		end else if (dist_in > cad_cfg.fast_distance) begin
			band.hi = cad_cfg.slow_high_ticks;
			band.lo = cad_cfg.slow_low_ticks;
		end else if (dist_in > cad_cfg.continuous_distance) begin
			band.hi = cad_cfg.fast_high_ticks;
			band.lo = cad_cfg.fast_low_ticks;
		end else begin
			band.hi   = dbc_pkg::LONG_HIGH_TIME_DEF;
			band.lo   = dbc_pkg::LONG_LOW_TIME_DEF;
			band.cont = 1'b1;
		end
		cad_cont = band.cont;
		if (cad_count != 16'd0) begin
			cad_count = cad_count - 16'd1;
			want = cad_phase ? band.hi : band.lo;
			if (want != cad_period) begin
				elapsed = cad_period - cad_count;
				if (elapsed < (cad_period >> 1) && elapsed < want) begin
					cad_count  = want;
					cad_period = want;
				end
			end
		end else if (!band.no_obj) begin
			if (!cad_phase) begin
				cad_phase  = 1'b1;
				cad_count  = band.hi;
				cad_period = band.hi;
				cad_tone   = 1'b1;
			end else begin
				cad_phase  = 1'b0;
				cad_count  = band.lo;
				cad_period = band.lo;
				if (!band.cont)
					cad_tone = 1'b0;
			end
		end else begin
			cad_phase  = 1'b0;
			cad_count  = band.lo;
			cad_period = band.lo;
			cad_tone   = 1'b0;
		end
		return '{tone: cad_tone, phase: cad_phase, cont: cad_cont};
	endfunction

	task automatic report_mismatch(input string what, input int exp_val, input int got_val);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
		mismatch_count++;
	endtask

	task automatic write_reg(input dbc_pkg::reg_idx_t idx, input logic [15:0] val);
		logic [dbc_pkg::DATA_W-1:0] data;
		data = $urandom();
		if (idx <= dbc_pkg::REG_CONT_DIST)
			data[7:0] = val[7:0];
		else
			data[15:0] = val;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			dbc_pkg::REG_MAX_DIST:  cad_cfg.max_distance        = data[7:0];
			dbc_pkg::REG_FAST_DIST: cad_cfg.fast_distance       = data[7:0];
			dbc_pkg::REG_CONT_DIST: cad_cfg.continuous_distance = data[7:0];
			dbc_pkg::REG_SLOW_HIGH: cad_cfg.slow_high_ticks     = data[15:0];
			dbc_pkg::REG_SLOW_LOW:  cad_cfg.slow_low_ticks      = data[15:0];
			dbc_pkg::REG_FAST_HIGH: cad_cfg.fast_high_ticks     = data[15:0];
			dbc_pkg::REG_FAST_LOW:  cad_cfg.fast_low_ticks      = data[15:0];
			dbc_pkg::REG_IDLE_LOW:  cad_cfg.idle_low_ticks      = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic send_distance(input logic [7:0] dist_in);
		int gap;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = dist_in;
		do @(posedge clk); while (!s_tready);
		pending_beeps.push_back(advance_cadence(dist_in));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_beeps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_ticks();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(16, 300));
			default: return 16'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [7:0] rand_threshold();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] near_threshold(input logic [7:0] thr);
		int v;
		v = int'(thr) + int'($urandom_range(0, 2)) - 1;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] pick_distance();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return near_threshold(cad_cfg.max_distance);
			2: return near_threshold(cad_cfg.fast_distance);
			default: return near_threshold(cad_cfg.continuous_distance);
		endcase
	endfunction

	task automatic randomize_config();
		int thr[3];
		foreach (thr[i])
			thr[i] = rand_threshold();
		if ($urandom_range(0, 1))
			thr.rsort();
		write_reg(dbc_pkg::REG_MAX_DIST, 16'(thr[0]));
		write_reg(dbc_pkg::REG_FAST_DIST, 16'(thr[1]));
		write_reg(dbc_pkg::REG_CONT_DIST, 16'(thr[2]));
		write_reg(dbc_pkg::REG_SLOW_HIGH, rand_ticks());
		write_reg(dbc_pkg::REG_SLOW_LOW, rand_ticks());
		write_reg(dbc_pkg::REG_FAST_HIGH, rand_ticks());
		write_reg(dbc_pkg::REG_FAST_LOW, rand_ticks());
		write_reg(dbc_pkg::REG_IDLE_LOW, rand_ticks());
	endtask

	task automatic test_zero_length_phases();
		logic [7:0] dists[8] = '{8'd201, 8'd150, 8'd150, 8'd75, 8'd75, 8'd201, 8'd10, 8'd10};
		write_reg(dbc_pkg::REG_MAX_DIST, 16'd200);
		write_reg(dbc_pkg::REG_FAST_DIST, 16'd100);
		write_reg(dbc_pkg::REG_CONT_DIST, 16'd50);
		write_reg(dbc_pkg::REG_SLOW_HIGH, 16'd0);
		write_reg(dbc_pkg::REG_SLOW_LOW, 16'd0);
		write_reg(dbc_pkg::REG_FAST_HIGH, 16'd0);
		write_reg(dbc_pkg::REG_FAST_LOW, 16'd0);
		write_reg(dbc_pkg::REG_IDLE_LOW, 16'd0);
		foreach (dists[i])
			send_distance(dists[i]);
	endtask

	task automatic test_band_edges();
		logic [7:0] dists[8] = '{8'd255, 8'd151, 8'd150, 8'd61, 8'd60, 8'd36, 8'd35, 8'd0};
		wait_idle();
		write_reg(dbc_pkg::REG_MAX_DIST, 16'(dbc_pkg::MAX_DIST_RST));
		write_reg(dbc_pkg::REG_FAST_DIST, 16'(dbc_pkg::FAST_DIST_RST));
		write_reg(dbc_pkg::REG_CONT_DIST, 16'(dbc_pkg::CONT_DIST_RST));
		write_reg(dbc_pkg::REG_SLOW_HIGH, 16'd3);
		write_reg(dbc_pkg::REG_SLOW_LOW, 16'd2);
		write_reg(dbc_pkg::REG_FAST_HIGH, 16'd1);
		write_reg(dbc_pkg::REG_FAST_LOW, 16'd2);
		write_reg(dbc_pkg::REG_IDLE_LOW, 16'd1);
		foreach (dists[i])
			send_distance(dists[i]);
	endtask

	task automatic test_threshold_extremes();
		wait_idle();
		write_reg(dbc_pkg::REG_MAX_DIST, 16'd0);
		write_reg(dbc_pkg::REG_FAST_DIST, 16'd255);
		write_reg(dbc_pkg::REG_CONT_DIST, 16'd255);
		write_reg(dbc_pkg::REG_SLOW_HIGH, 16'hFFFF);
		write_reg(dbc_pkg::REG_SLOW_LOW, 16'hFFFF);
		send_distance(8'd0);
		send_distance(8'd1);
		send_distance(8'd255);
		wait_idle();
		write_reg(dbc_pkg::REG_MAX_DIST, 16'd255);
		write_reg(dbc_pkg::REG_FAST_DIST, 16'd0);
		send_distance(8'd255);
		send_distance(8'd0);
	endtask

	task automatic test_random_settings(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			wait_idle();
			randomize_config();
			idling_on = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < per_phase; n++)
				send_distance(pick_distance());
		end
	endtask

	task automatic test_full_rate(input int count);
		wait_idle();
		idling_on = 1'b0;
		randomize_config();
		for (int n = 0; n < count; n++)
			send_distance(pick_distance());
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beeps.size() == 0) begin
				report_mismatch("result with no request pending", 0, int'(m_tdata));
			end else begin
				want_beep = pending_beeps.pop_front();
				if (m_tdata[0] !== want_beep.tone)
					report_mismatch("tone_on", int'(want_beep.tone), int'(m_tdata[0]));
				if (m_tdata[1] !== want_beep.phase)
					report_mismatch("phase_high", int'(want_beep.phase), int'(m_tdata[1]));
				if (m_tdata[2] !== want_beep.cont)
					report_mismatch("continuous", int'(want_beep.cont), int'(m_tdata[2]));
				if (m_tdata[7:3] !== 5'd0)
					report_mismatch("tdata padding", 0, int'(m_tdata[7:3]));
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		mismatch_count = 0;
		idling_on      = 1'b1;
		reset_cadence_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_length_phases();
		test_band_edges();
		test_threshold_extremes();
		test_random_settings(8, 70);
		test_full_rate(80);

		wait_idle();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("** distance_beep_cadence_unit: PASSED **");
		else
			$display("** distance_beep_cadence_unit: FAILED **");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/dbc_pkg.sv
rtl/core/dbc_regs.sv
rtl/core/dbc_band.sv
rtl/core/dbc_cadence.sv
rtl/core/distance_beep_cadence_unit.sv
sim/distance_beep_cadence_unit_tb.sv
